// ===== design/cpl_pkg.sv =====
// Shared types, widths, codes and reset values for the contact-process lattice update engine.
package cpl_pkg;

   localparam int SITE_W     = 16;
   localparam int DIR_W      = 2;
   localparam int DRAW_W     = 16;
   localparam int COUNT_W    = 17;
   localparam int SUM_W      = 30;
   localparam int THR_W      = 17;
   localparam int DATA_W     = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_IDX_BIT = 2;
   localparam int RECIP_W    = SITE_W + 1;
   localparam int PROD_W     = SITE_W + RECIP_W;
   localparam int REM_W      = SITE_W + 1;

   localparam int SIDE_DEFAULT = 256;

   localparam logic [THR_W-1:0]   DEATH_RESET = 17'd39322;
   localparam logic [THR_W-1:0]   BIRTH_RESET = 17'd65536;
   localparam logic [COUNT_W-1:0] COUNT_SEED  = 17'd1;
   localparam logic [SUM_W-1:0]   SUM_SEED    = 30'd0;

   localparam logic REG_DEATH = 1'b0;
   localparam logic REG_BIRTH = 1'b1;

   localparam logic MODE_UPDATE = 1'b0;
   localparam logic MODE_SEED   = 1'b1;

   localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd0;
   localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
   localparam logic [DIR_W-1:0] DIR_UP    = 2'd2;
   localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd3;

   typedef enum logic [2:0] {
      STATE_IDLE,
      STATE_CLEAR,
      STATE_SPLIT,
      STATE_NBR,
      STATE_SQR,
      STATE_SUM,
      STATE_COMMIT
   } state_type;

endpackage

// ===== design/cpl_bit_ram.sv =====
// Single-bit-wide occupancy memory with one write port and one registered read port.
module cpl_bit_ram #(
   parameter int DEPTH = cpl_pkg::SIDE_DEFAULT * cpl_pkg::SIDE_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic [AW-1:0] rd_addr,
   output logic          rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic          wr_data
);

   logic mem [DEPTH];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/contact_process_lattice_update.sv =====
// Top level of the contact-process lattice update engine with its control sequencer.
//
// The lattice of SIDE by SIDE sites, with periodic wrap, is held one bit per site in a
// synchronous memory with a single read port. An update transfer runs as follows: the
// site bit is read while the site index is split into row and column by a reciprocal
// multiply, then the neighbour bit is read, the squared distance is formed and the site
// is written back if it changes. The next transfer is taken once the sequencer is back in
// idle, so a new update is not accepted until the last one has been committed.
// A reinitialise transfer sweeps the whole memory, one site per cycle, before its result
// appears. After reset the same clearing pass runs before the first transfer is accepted;
// configuration writes are taken throughout.
module contact_process_lattice_update #(
   parameter int SIDE = cpl_pkg::SIDE_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_mode,
   input  logic [cpl_pkg::SITE_W-1:0]       req_site_index,
   input  logic [cpl_pkg::DIR_W-1:0]        req_direction,
   input  logic [cpl_pkg::DRAW_W-1:0]       req_random_draw,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [cpl_pkg::COUNT_W-1:0]      rsp_active_count,
   output logic [cpl_pkg::SUM_W-1:0]        rsp_distance_sum,
   output logic                             rsp_site_changed,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [cpl_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [cpl_pkg::DATA_W-1:0]       pwdata,
   output logic [cpl_pkg::DATA_W-1:0]       prdata,
   output logic                             pready
);

   localparam int CW      = $clog2(SIDE);
   localparam int CELLS   = SIDE * SIDE;
   localparam int AW      = $clog2(CELLS);
   localparam int HALF    = SIDE / 2;
   localparam int CENTRE  = HALF * SIDE + HALF;
   localparam int K_SHIFT = cpl_pkg::SITE_W + CW;
   localparam int SQ_W    = 2 * CW;
   localparam int DIST_W  = SQ_W + 1;

   localparam logic [cpl_pkg::RECIP_W-1:0] RECIP =
      cpl_pkg::RECIP_W'((64'd1 << K_SHIFT) / SIDE);
   localparam logic [cpl_pkg::REM_W-1:0] REM_SIDE = cpl_pkg::REM_W'(SIDE);
   localparam logic [CW-1:0] C_HALF = CW'(HALF);
   localparam logic [CW-1:0] C_LAST = CW'(SIDE - 1);
   localparam logic [CW-1:0] C_ONE  = CW'(1);
   localparam logic [AW-1:0] A_ONE    = AW'(1);
   localparam logic [AW-1:0] A_SIDE   = AW'(SIDE);
   localparam logic [AW-1:0] A_SIDE_M1 = AW'(SIDE - 1);
   localparam logic [AW-1:0] A_WRAP   = AW'(CELLS - SIDE);
   localparam logic [AW-1:0] A_CENTRE = AW'(CENTRE);
   localparam logic [AW-1:0] A_LAST   = AW'(CELLS - 1);
   localparam logic [31:0]   CELLS_32 = 32'(CELLS);

   cpl_pkg::state_type state_ff, state_in;

   logic [AW-1:0]                   clr_addr_ff, clr_addr_in;
   logic                            item_ff, item_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [cpl_pkg::THR_W-1:0]       death_ff, death_in;
   logic [cpl_pkg::THR_W-1:0]       birth_ff, birth_in;
   logic [cpl_pkg::COUNT_W-1:0]     count_ff, count_in;
   logic [cpl_pkg::SUM_W-1:0]       sum_ff, sum_in;

   logic [cpl_pkg::SITE_W-1:0]      site_ff;
   logic [cpl_pkg::DIR_W-1:0]       dir_ff;
   logic [cpl_pkg::DRAW_W-1:0]      draw_ff;
   logic [cpl_pkg::PROD_W-1:0]      prod_ff;
   logic                            occ_ff;
   logic                            nbr_ff;
   logic [CW-1:0]                   row_ff;
   logic [CW-1:0]                   col_ff;
   logic [CW-1:0]                   dx_ff;
   logic [CW-1:0]                   dy_ff;
   logic [SQ_W-1:0]                 sqx_ff;
   logic [SQ_W-1:0]                 sqy_ff;
   logic [DIST_W-1:0]               dist_ff;
   logic                            fire_ff;
   logic [cpl_pkg::COUNT_W-1:0]     out_count_ff;
   logic [cpl_pkg::SUM_W-1:0]       out_sum_ff;
   logic                            out_changed_ff;

   logic                            req_fire;
   logic                            rsp_free;
   logic                            rsp_load;
   logic                            csr_write;
   logic                            in_range;
   logic [AW-1:0]                   rd_addr;
   logic                            rd_bit;
   logic                            wr_en;
   logic [AW-1:0]                   wr_addr;
   logic                            wr_data;
   logic [AW-1:0]                   site_addr;
   logic [AW-1:0]                   nbr_addr;
   logic [CW-1:0]                   q_est;
   logic [cpl_pkg::REM_W-1:0]       r_est;
   logic                            r_big;
   logic [CW-1:0]                   row_calc;
   logic [CW-1:0]                   col_calc;
   logic                            fire_calc;
   logic [cpl_pkg::COUNT_W-1:0]     count_upd;
   logic [cpl_pkg::SUM_W-1:0]       sum_upd;

   cpl_bit_ram #(
      .DEPTH (CELLS),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_data (rd_bit),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign req_fire  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign csr_write = psel && penable && pwrite && pready;
   assign in_range  = {16'd0, req_site_index} < CELLS_32;
   assign site_addr = AW'(site_ff);

   // Row and column from the site index; the reciprocal estimate is at most one low.
   always_comb begin
      q_est    = CW'(prod_ff >> K_SHIFT);
      r_est    = cpl_pkg::REM_W'(site_ff) -
                 cpl_pkg::REM_W'(cpl_pkg::REM_W'(q_est) * REM_SIDE);
      r_big    = r_est >= REM_SIDE;
      row_calc = r_big ? q_est + C_ONE : q_est;
      col_calc = r_big ? CW'(r_est - REM_SIDE) : CW'(r_est);
   end

   always_comb begin
      case (dir_ff)
         cpl_pkg::DIR_LEFT: begin
            nbr_addr = (col_ff == '0) ? site_addr + A_SIDE_M1 : site_addr - A_ONE;
         end
         cpl_pkg::DIR_RIGHT: begin
            nbr_addr = (col_ff == C_LAST) ? site_addr - A_SIDE_M1 : site_addr + A_ONE;
         end
         cpl_pkg::DIR_UP: begin
            nbr_addr = (row_ff == '0) ? site_addr + A_WRAP : site_addr - A_SIDE;
         end
         cpl_pkg::DIR_DOWN: begin
            nbr_addr = (row_ff == C_LAST) ? site_addr - A_WRAP : site_addr + A_SIDE;
         end
         default: begin
            nbr_addr = site_addr;
         end
      endcase
   end

   always_comb begin
      if (occ_ff) begin
         fire_calc = {1'b0, draw_ff} < death_ff;
      end else begin
         fire_calc = nbr_ff && ({1'b0, draw_ff} < birth_ff);
      end
      count_upd = occ_ff ? count_ff - cpl_pkg::COUNT_W'(1) : count_ff + cpl_pkg::COUNT_W'(1);
      sum_upd   = occ_ff ? sum_ff - cpl_pkg::SUM_W'(dist_ff) : sum_ff + cpl_pkg::SUM_W'(dist_ff);
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rd_addr   = site_addr;
      wr_en     = 1'b0;
      wr_addr   = site_addr;
      wr_data   = !occ_ff;
      rsp_load  = 1'b0;
      case (state_ff)
         cpl_pkg::STATE_IDLE: begin
            req_ready = 1'b1;
            rd_addr   = AW'(req_site_index);
            if (req_valid) begin
               if (req_mode == cpl_pkg::MODE_SEED) begin
                  state_in = cpl_pkg::STATE_CLEAR;
               end else if (in_range) begin
                  state_in = cpl_pkg::STATE_SPLIT;
               end else begin
                  state_in = cpl_pkg::STATE_COMMIT;
               end
            end
         end
         cpl_pkg::STATE_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_ff;
            wr_data = clr_addr_ff == A_CENTRE;
            if (clr_addr_ff == A_LAST) begin
               state_in = item_ff ? cpl_pkg::STATE_COMMIT : cpl_pkg::STATE_IDLE;
            end
         end
         cpl_pkg::STATE_SPLIT: begin
            state_in = cpl_pkg::STATE_NBR;
         end
         cpl_pkg::STATE_NBR: begin
            rd_addr  = nbr_addr;
            state_in = cpl_pkg::STATE_SQR;
         end
         cpl_pkg::STATE_SQR: begin
            state_in = cpl_pkg::STATE_SUM;
         end
         cpl_pkg::STATE_SUM: begin
            state_in = cpl_pkg::STATE_COMMIT;
         end
         cpl_pkg::STATE_COMMIT: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               wr_en    = fire_ff;
               state_in = cpl_pkg::STATE_IDLE;
            end
         end
         default: begin
            state_in = cpl_pkg::STATE_IDLE;
         end
      endcase
   end

   always_comb begin
      clr_addr_in  = clr_addr_ff;
      item_in      = item_ff;
      rsp_valid_in = rsp_valid_ff;
      death_in     = death_ff;
      birth_in     = birth_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      if (state_ff == cpl_pkg::STATE_CLEAR) begin
         clr_addr_in = (clr_addr_ff == A_LAST) ? '0 : clr_addr_ff + A_ONE;
         count_in    = cpl_pkg::COUNT_SEED;
         sum_in      = cpl_pkg::SUM_SEED;
      end
      if (req_fire) begin
         item_in = req_mode == cpl_pkg::MODE_SEED;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         if (fire_ff) begin
            count_in = count_upd;
            sum_in   = sum_upd;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_write) begin
         case (paddr[cpl_pkg::CSR_IDX_BIT])
            cpl_pkg::REG_DEATH: begin
               death_in = pwdata[cpl_pkg::THR_W-1:0];
            end
            cpl_pkg::REG_BIRTH: begin
               birth_in = pwdata[cpl_pkg::THR_W-1:0];
            end
            default: begin
               death_in = death_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cpl_pkg::STATE_CLEAR;
         clr_addr_ff  <= '0;
         item_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         death_ff     <= cpl_pkg::DEATH_RESET;
         birth_ff     <= cpl_pkg::BIRTH_RESET;
         count_ff     <= cpl_pkg::COUNT_SEED;
         sum_ff       <= cpl_pkg::SUM_SEED;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         item_ff      <= item_in;
         rsp_valid_ff <= rsp_valid_in;
         death_ff     <= death_in;
         birth_ff     <= birth_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         site_ff <= req_site_index;
         dir_ff  <= req_direction;
         draw_ff <= req_random_draw;
         prod_ff <= cpl_pkg::PROD_W'(req_site_index) * cpl_pkg::PROD_W'(RECIP);
         fire_ff <= 1'b0;
      end
      case (state_ff)
         cpl_pkg::STATE_SPLIT: begin
            occ_ff <= rd_bit;
            row_ff <= row_calc;
            col_ff <= col_calc;
         end
         cpl_pkg::STATE_NBR: begin
            dx_ff <= (col_ff >= C_HALF) ? col_ff - C_HALF : C_HALF - col_ff;
            dy_ff <= (row_ff >= C_HALF) ? row_ff - C_HALF : C_HALF - row_ff;
         end
         cpl_pkg::STATE_SQR: begin
            nbr_ff <= rd_bit;
            sqx_ff <= SQ_W'(dx_ff) * SQ_W'(dx_ff);
            sqy_ff <= SQ_W'(dy_ff) * SQ_W'(dy_ff);
         end
         cpl_pkg::STATE_SUM: begin
            dist_ff <= DIST_W'(sqx_ff) + DIST_W'(sqy_ff);
            fire_ff <= fire_calc;
         end
         default: begin
            occ_ff <= occ_ff;
         end
      endcase
      if (rsp_load) begin
         out_count_ff   <= fire_ff ? count_upd : count_ff;
         out_sum_ff     <= fire_ff ? sum_upd : sum_ff;
         out_changed_ff <= fire_ff;
      end
   end

   always_comb begin
      case (paddr[cpl_pkg::CSR_IDX_BIT])
         cpl_pkg::REG_DEATH: begin
            prdata = cpl_pkg::DATA_W'(death_ff);
         end
         cpl_pkg::REG_BIRTH: begin
            prdata = cpl_pkg::DATA_W'(birth_ff);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   assign pready           = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_active_count = out_count_ff;
   assign rsp_distance_sum = out_sum_ff;
   assign rsp_site_changed = out_changed_ff;

endmodule

// ===== verif/contact_process_lattice_update_tb.sv =====
// Self-checking testbench for the contact-process lattice update engine.
`timescale 1ns / 1ps

module contact_process_lattice_update_tb;

   localparam int SIDE   = cpl_pkg::SIDE_DEFAULT;
   localparam int CELLS  = SIDE * SIDE;
   localparam int HALF   = SIDE / 2;
   localparam int CENTRE = HALF * SIDE + HALF;

   typedef struct packed {
      logic [cpl_pkg::COUNT_W-1:0] count;
      logic [cpl_pkg::SUM_W-1:0]   sum;
      logic                        changed;
   } totals_type;

   typedef struct packed {
      logic                        mode;
      logic [cpl_pkg::SITE_W-1:0]  site;
      logic [cpl_pkg::DIR_W-1:0]   dir;
      logic [cpl_pkg::DRAW_W-1:0]  draw;
      logic                        typed;
      totals_type                  want;
   } lattice_row_type;

   localparam lattice_row_type DIRECTED [17] = '{
      '{cpl_pkg::MODE_UPDATE, 16'd0, cpl_pkg::DIR_LEFT, 16'd0,
        1'b1, '{17'd1, 30'd0, 1'b0}},
      '{cpl_pkg::MODE_UPDATE, 16'hFFFF, cpl_pkg::DIR_DOWN, 16'hFFFF,
        1'b1, '{17'd1, 30'd0, 1'b0}},
      '{cpl_pkg::MODE_UPDATE, 16'(CENTRE+1), cpl_pkg::DIR_LEFT, 16'hFFFF,
        1'b1, '{17'd2, 30'd1, 1'b1}},
      '{cpl_pkg::MODE_UPDATE, 16'(CENTRE-1), cpl_pkg::DIR_RIGHT, 16'd0,
        1'b1, '{17'd3, 30'd2, 1'b1}},
      '{cpl_pkg::MODE_UPDATE, 16'(CENTRE-SIDE), cpl_pkg::DIR_DOWN, 16'h5555,
        1'b1, '{17'd4, 30'd3, 1'b1}},
      '{cpl_pkg::MODE_UPDATE, 16'(CENTRE+SIDE), cpl_pkg::DIR_UP, 16'hAAAA,
        1'b1, '{17'd5, 30'd4, 1'b1}},
      '{cpl_pkg::MODE_UPDATE, 16'(CENTRE), cpl_pkg::DIR_UP, 16'd39321,
        1'b1, '{17'd4, 30'd4, 1'b1}},
      '{cpl_pkg::MODE_UPDATE, 16'(CENTRE+1), cpl_pkg::DIR_RIGHT, 16'd39322,
        1'b1, '{17'd4, 30'd4, 1'b0}},
      '{cpl_pkg::MODE_UPDATE, 16'(CENTRE+1), cpl_pkg::DIR_LEFT, 16'hFFFF,
        1'b1, '{17'd4, 30'd4, 1'b0}},
      '{cpl_pkg::MODE_UPDATE, 16'(CENTRE+1), cpl_pkg::DIR_DOWN, 16'd0,
        1'b1, '{17'd3, 30'd3, 1'b1}},
      '{cpl_pkg::MODE_UPDATE, 16'(CENTRE), cpl_pkg::DIR_RIGHT, 16'd100,
        1'b0, '0},
      '{cpl_pkg::MODE_UPDATE, 16'(CENTRE), cpl_pkg::DIR_LEFT, 16'd100,
        1'b0, '0},
      '{cpl_pkg::MODE_UPDATE, 16'(CENTRE+2), cpl_pkg::DIR_LEFT, 16'd0,
        1'b0, '0},
      '{cpl_pkg::MODE_SEED, 16'hFFFF, cpl_pkg::DIR_DOWN, 16'hFFFF,
        1'b1, '{17'd1, 30'd0, 1'b0}},
      '{cpl_pkg::MODE_UPDATE, 16'(CENTRE), cpl_pkg::DIR_DOWN, 16'd0,
        1'b1, '{17'd0, 30'd0, 1'b1}},
      '{cpl_pkg::MODE_UPDATE, 16'(CENTRE+1), cpl_pkg::DIR_LEFT, 16'd0,
        1'b1, '{17'd0, 30'd0, 1'b0}},
      '{cpl_pkg::MODE_SEED, 16'd0, cpl_pkg::DIR_LEFT, 16'd0,
        1'b1, '{17'd1, 30'd0, 1'b0}}
   };

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic                           req_mode = cpl_pkg::MODE_UPDATE;
   logic [cpl_pkg::SITE_W-1:0]     req_site_index = '0;
   logic [cpl_pkg::DIR_W-1:0]      req_direction = cpl_pkg::DIR_LEFT;
   logic [cpl_pkg::DRAW_W-1:0]     req_random_draw = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [cpl_pkg::COUNT_W-1:0]    rsp_active_count;
   logic [cpl_pkg::SUM_W-1:0]      rsp_distance_sum;
   logic                           rsp_site_changed;
   logic                           psel = 1'b0;
   logic                           penable = 1'b0;
   logic                           pwrite = 1'b0;
   logic [cpl_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [cpl_pkg::DATA_W-1:0]     pwdata = '0;
   logic [cpl_pkg::DATA_W-1:0]     prdata;
   logic                           pready;

   bit                             lattice [CELLS];
   logic [cpl_pkg::COUNT_W-1:0]    live_count;
   logic [cpl_pkg::SUM_W-1:0]      spread_sum;
   logic [cpl_pkg::THR_W-1:0]      death_level;
   logic [cpl_pkg::THR_W-1:0]      birth_level;
   int                             live_sites [$];
   totals_type                     awaited_totals [$];
   int                             error_count = 0;
   int                             sender_idle_pct = 0;
   int                             receiver_stall_pct = 0;
   int                             seeds_left = 2;

   contact_process_lattice_update dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_site_index   (req_site_index),
      .req_direction    (req_direction),
      .req_random_draw  (req_random_draw),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_active_count (rsp_active_count),
      .rsp_distance_sum (rsp_distance_sum),
      .rsp_site_changed (rsp_site_changed),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #2 clock = ~clock;

   function automatic int neighbour_of(int site, logic [cpl_pkg::DIR_W-1:0] dir);
      int col;
      int row;
      col = site % SIDE;
      row = site / SIDE;
      case (dir)
         cpl_pkg::DIR_LEFT: begin
            col = (col + SIDE - 1) % SIDE;
         end
         cpl_pkg::DIR_RIGHT: begin
            col = (col + 1) % SIDE;
         end
         cpl_pkg::DIR_UP: begin
            row = (row + SIDE - 1) % SIDE;
         end
         default: begin
            row = (row + 1) % SIDE;
         end
      endcase
      return row * SIDE + col;
   endfunction

   function automatic void reseed_lattice();
      foreach (lattice[i]) lattice[i] = 1'b0;
      lattice[CENTRE] = 1'b1;
      live_count = cpl_pkg::COUNT_SEED;
      spread_sum = cpl_pkg::SUM_SEED;
      live_sites.delete();
      live_sites.insert(live_sites.size(), CENTRE);
   endfunction

   function automatic totals_type advance_lattice(logic mode,
                                                  logic [cpl_pkg::SITE_W-1:0] site,
                                                  logic [cpl_pkg::DIR_W-1:0] dir,
                                                  logic [cpl_pkg::DRAW_W-1:0] draw);
      totals_type t;
      int         s;
      int         col;
      int         row;
      int         dsq;
      s = site;
      t = '0;
      if (mode == cpl_pkg::MODE_SEED) begin
         reseed_lattice();
      end else if (s < CELLS) begin
         col = s % SIDE;
         row = s / SIDE;
         dsq = (col - HALF) * (col - HALF) + (row - HALF) * (row - HALF);
         if (lattice[s]) begin
            if ({1'b0, draw} < death_level) begin
               lattice[s] = 1'b0;
               live_count = live_count - 1'b1;
               spread_sum = spread_sum - cpl_pkg::SUM_W'(dsq);
               t.changed = 1'b1;
               for (int k = 0; k < live_sites.size(); k++) begin
                  if (live_sites[k] == s) begin
                     live_sites.delete(k);
                     break;
                  end
               end
            end
         end else if (lattice[neighbour_of(s, dir)] && {1'b0, draw} < birth_level) begin
            lattice[s] = 1'b1;
            live_count = live_count + 1'b1;
            spread_sum = spread_sum + cpl_pkg::SUM_W'(dsq);
            t.changed = 1'b1;
            live_sites.insert(live_sites.size(), s);
         end
      end
      t.count = live_count;
      t.sum = spread_sum;
      return t;
   endfunction

   task automatic transfer_item(logic mode, logic [cpl_pkg::SITE_W-1:0] site,
                                logic [cpl_pkg::DIR_W-1:0] dir,
                                logic [cpl_pkg::DRAW_W-1:0] draw, logic typed,
                                totals_type want);
      totals_type got;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_site_index <= site;
      req_direction <= dir;
      req_random_draw <= draw;
      do @(posedge clock); while (!req_ready);
      got = advance_lattice(mode, site, dir, draw);
      awaited_totals.insert(awaited_totals.size(), typed ? want : got);
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_totals.size() != 0);
      @(negedge clock);
   endtask

   task automatic csr_transfer(logic is_write, logic idx, logic [cpl_pkg::DATA_W-1:0] wdata,
                               output logic [cpl_pkg::DATA_W-1:0] rdata);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= is_write;
      paddr <= cpl_pkg::CSR_ADDR_W'(idx) << cpl_pkg::CSR_IDX_BIT;
      pwdata <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic check_threshold(logic idx);
      logic [cpl_pkg::DATA_W-1:0] value;
      logic [cpl_pkg::THR_W-1:0]  want;
      csr_transfer(1'b0, idx, '0, value);
      want = (idx == cpl_pkg::REG_DEATH) ? death_level : birth_level;
      if (value[cpl_pkg::THR_W-1:0] !== want) begin
         $error("threshold %0d: expected %0d, actual %0d", idx, want,
                value[cpl_pkg::THR_W-1:0]);
         error_count++;
      end
   endtask

   task automatic set_threshold(logic idx, logic [cpl_pkg::DATA_W-1:0] value);
      logic [cpl_pkg::DATA_W-1:0] unused;
      csr_transfer(1'b1, idx, value, unused);
      if (idx == cpl_pkg::REG_DEATH) begin
         death_level = value[cpl_pkg::THR_W-1:0];
      end else begin
         birth_level = value[cpl_pkg::THR_W-1:0];
      end
      check_threshold(idx);
   endtask

   // Grows the centre row leftwards and the centre column upwards to the lattice edges and across the wrap.
   // The death threshold is expected at one half, so draws below 32768 empty a site.
   task automatic grow_cross();
      for (int c = HALF - 1; c >= 0; c--) begin
         transfer_item(cpl_pkg::MODE_UPDATE, cpl_pkg::SITE_W'(HALF * SIDE + c),
                       cpl_pkg::DIR_RIGHT, cpl_pkg::DRAW_W'($urandom), 1'b0, '0);
      end
      transfer_item(cpl_pkg::MODE_UPDATE, cpl_pkg::SITE_W'(HALF * SIDE + SIDE - 1),
                    cpl_pkg::DIR_RIGHT, cpl_pkg::DRAW_W'($urandom), 1'b0, '0);
      transfer_item(cpl_pkg::MODE_UPDATE, cpl_pkg::SITE_W'(HALF * SIDE), cpl_pkg::DIR_LEFT,
                    cpl_pkg::DRAW_W'($urandom_range(32767)), 1'b0, '0);
      transfer_item(cpl_pkg::MODE_UPDATE, cpl_pkg::SITE_W'(HALF * SIDE), cpl_pkg::DIR_LEFT,
                    cpl_pkg::DRAW_W'($urandom), 1'b0, '0);
      for (int r = HALF - 1; r >= 0; r--) begin
         transfer_item(cpl_pkg::MODE_UPDATE, cpl_pkg::SITE_W'(r * SIDE + HALF),
                       cpl_pkg::DIR_DOWN, cpl_pkg::DRAW_W'($urandom), 1'b0, '0);
      end
      transfer_item(cpl_pkg::MODE_UPDATE, cpl_pkg::SITE_W'((SIDE - 1) * SIDE + HALF),
                    cpl_pkg::DIR_DOWN, cpl_pkg::DRAW_W'($urandom), 1'b0, '0);
      transfer_item(cpl_pkg::MODE_UPDATE, cpl_pkg::SITE_W'(HALF), cpl_pkg::DIR_UP,
                    cpl_pkg::DRAW_W'($urandom_range(32767)), 1'b0, '0);
      transfer_item(cpl_pkg::MODE_UPDATE, cpl_pkg::SITE_W'(HALF), cpl_pkg::DIR_UP,
                    cpl_pkg::DRAW_W'($urandom), 1'b0, '0);
   endtask

   // Most updates aim at a site beside an occupied one, pointing back at it.
   task automatic random_updates(int n);
      int                         pick;
      int                         anchor;
      logic [cpl_pkg::DIR_W-1:0]  dd;
      logic [cpl_pkg::DIR_W-1:0]  back;
      logic [cpl_pkg::DRAW_W-1:0] draw;
      repeat (n) begin
         pick = $urandom_range(99);
         dd = cpl_pkg::DIR_W'($urandom_range(3));
         case ($urandom_range(7))
            0: begin
               draw = '0;
            end
            1: begin
               draw = '1;
            end
            default: begin
               draw = cpl_pkg::DRAW_W'($urandom);
            end
         endcase
         if (seeds_left > 0 && (live_sites.size() == 0 || $urandom_range(199) == 0)) begin
            seeds_left--;
            transfer_item(cpl_pkg::MODE_SEED, cpl_pkg::SITE_W'($urandom), dd, draw, 1'b0, '0);
         end else if (live_sites.size() != 0 && pick < 70) begin
            anchor = live_sites[$urandom_range(live_sites.size() - 1)];
            back = (dd == cpl_pkg::DIR_LEFT) ? cpl_pkg::DIR_RIGHT :
                   (dd == cpl_pkg::DIR_RIGHT) ? cpl_pkg::DIR_LEFT :
                   (dd == cpl_pkg::DIR_UP) ? cpl_pkg::DIR_DOWN : cpl_pkg::DIR_UP;
            transfer_item(cpl_pkg::MODE_UPDATE, cpl_pkg::SITE_W'(neighbour_of(anchor, dd)),
                          back, draw, 1'b0, '0);
         end else if (live_sites.size() != 0 && pick < 85) begin
            anchor = live_sites[$urandom_range(live_sites.size() - 1)];
            transfer_item(cpl_pkg::MODE_UPDATE, cpl_pkg::SITE_W'(anchor), dd, draw, 1'b0, '0);
         end else begin
            transfer_item(cpl_pkg::MODE_UPDATE, cpl_pkg::SITE_W'($urandom), dd, draw,
                          1'b0, '0);
         end
      end
   endtask

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      totals_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_totals.size() == 0) begin
            $error("result transfer with no expectation waiting");
            error_count++;
         end else begin
            want = awaited_totals.pop_front();
            if (rsp_active_count !== want.count) begin
               $error("active_count: expected %0d, actual %0d", want.count, rsp_active_count);
               error_count++;
            end
            if (rsp_distance_sum !== want.sum) begin
               $error("distance_sum: expected %0d, actual %0d", want.sum, rsp_distance_sum);
               error_count++;
            end
            if (rsp_site_changed !== want.changed) begin
               $error("site_changed: expected %0d, actual %0d", want.changed, rsp_site_changed);
               error_count++;
            end
         end
      end
   end

   initial begin
      reseed_lattice();
      death_level = cpl_pkg::DEATH_RESET;
      birth_level = cpl_pkg::BIRTH_RESET;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      check_threshold(cpl_pkg::REG_DEATH);
      check_threshold(cpl_pkg::REG_BIRTH);

      foreach (DIRECTED[i]) begin
         transfer_item(DIRECTED[i].mode, DIRECTED[i].site, DIRECTED[i].dir, DIRECTED[i].draw,
                       DIRECTED[i].typed, DIRECTED[i].want);
      end
      settle();

      set_threshold(cpl_pkg::REG_DEATH, 32'd32768);
      set_threshold(cpl_pkg::REG_BIRTH, 32'd65536);
      grow_cross();
      settle();

      sender_idle_pct = 75;
      set_threshold(cpl_pkg::REG_DEATH, 32'd0);
      random_updates(150);
      settle();

      sender_idle_pct = 0;
      receiver_stall_pct = 75;
      set_threshold(cpl_pkg::REG_DEATH, 32'h0001_FFFF);
      set_threshold(cpl_pkg::REG_BIRTH, 32'd32768);
      random_updates(150);
      settle();

      sender_idle_pct = 10;
      receiver_stall_pct = 10;
      set_threshold(cpl_pkg::REG_DEATH, 32'd19661);
      set_threshold(cpl_pkg::REG_BIRTH, 32'd65536);
      random_updates(200);
      settle();

      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      set_threshold(cpl_pkg::REG_DEATH, 32'd65536);
      set_threshold(cpl_pkg::REG_BIRTH, 32'hFFFE_0000);
      random_updates(80);
      settle();

      receiver_stall_pct = 75;
      set_threshold(cpl_pkg::REG_DEATH, 32'd39322);
      set_threshold(cpl_pkg::REG_BIRTH, 32'h0001_FFFF);
      random_updates(120);
      settle();

      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
